/* design/naes_pkg.sv */
// ----------------------------------------------------------------------------
// naes_pkg
// Shared types, constants and microcode for the next alarm event selector.
// ----------------------------------------------------------------------------
package naes_pkg;

  localparam int EVENT_SLOTS_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int DUR_W   = 8;
  localparam int SPD_W   = 7;
  localparam int SECS_W  = 17;
  localparam int PWM_W   = 10;
  localparam int STAT_W  = 2;

  localparam logic [HOUR_W-1:0] MAX_HOUR   = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MAX_MINUTE = MIN_W'(59);
  localparam logic [SPD_W-1:0]  MAX_SPEED  = SPD_W'(100);

  localparam logic [SECS_W-1:0] SECS_PER_HOUR   = SECS_W'(3600);
  localparam logic [SECS_W-1:0] SECS_PER_MINUTE = SECS_W'(60);

  // speed * 1023 / 100 as a multiply by a scaled reciprocal of 100/1023;
  // exact for every speed up to MAX_SPEED (100).
  localparam int                PWM_SHIFT = 14;
  localparam int                RECIP_W   = 18;
  localparam logic [RECIP_W-1:0] PWM_RECIP = RECIP_W'(167609);
  localparam int                PROD_W    = RECIP_W + SPD_W;

  typedef enum logic [STAT_W-1:0] {
    ST_WR_OK  = 2'd0,
    ST_WR_REJ = 2'd1,
    ST_FOUND  = 2'd2,
    ST_NONE   = 2'd3
  } naes_status_e;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [DUR_W-1:0]  duration;
    logic [SPD_W-1:0]  speed;
  } naes_entry_t;

  // Jump conditions of the sequencer
  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_IS_WRITE,
    COND_MORE,
    COND_OUT_BUSY
  } naes_cond_e;

  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] STEP_ACCEPT   = 3'd0;
  localparam logic [PC_W-1:0] STEP_DISPATCH = 3'd1;
  localparam logic [PC_W-1:0] STEP_PRIME    = 3'd2;
  localparam logic [PC_W-1:0] STEP_SCAN     = 3'd3;
  localparam logic [PC_W-1:0] STEP_RESULT   = 3'd4;
  localparam logic [PC_W-1:0] STEP_WRITE    = 3'd5;

  typedef struct packed {
    logic            accept;      // offer in_ready, clear search state
    logic            issue_read;  // read slot at scan counter, advance it
    logic            compare;     // fold last read slot into the best match
    logic            load_query;  // commit query result to output register
    logic            load_write;  // commit table write and its status
    naes_cond_e      cond;
    logic [PC_W-1:0] target;
    logic            done;        // fall through to the first step
  } naes_ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_write;
    logic more;
    logic out_busy;
  } naes_flags_t;

  function automatic naes_ctrl_t ucode_fetch(logic [PC_W-1:0] pc);
    naes_ctrl_t w;
    w = '{accept: 1'b0, issue_read: 1'b0, compare: 1'b0, load_query: 1'b0,
          load_write: 1'b0, cond: COND_NONE, target: STEP_ACCEPT, done: 1'b0};
    unique case (pc)
      STEP_ACCEPT: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_IN;
        w.target = STEP_ACCEPT;
      end
      STEP_DISPATCH: begin
        w.cond   = COND_IS_WRITE;
        w.target = STEP_WRITE;
      end
      STEP_PRIME: begin
        w.issue_read = 1'b1;
      end
      STEP_SCAN: begin
        w.issue_read = 1'b1;
        w.compare    = 1'b1;
        w.cond       = COND_MORE;
        w.target     = STEP_SCAN;
      end
      STEP_RESULT: begin
        w.load_query = 1'b1;
        w.cond       = COND_OUT_BUSY;
        w.target     = STEP_RESULT;
        w.done       = 1'b1;
      end
      STEP_WRITE: begin
        w.load_write = 1'b1;
        w.cond       = COND_OUT_BUSY;
        w.target     = STEP_WRITE;
        w.done       = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/next_alarm_event_select.sv */
// ----------------------------------------------------------------------------
// next_alarm_event_select
// Scheduled event table with write and next-event query transactions.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  in      | input     | in_valid_i/in_ready_o   | req_type .. current_seconds
//  out     | output    | out_valid_o/out_ready_i | status .. pwm_compare
//
// A write goes from acceptance through the dispatch and write steps to a result
// in the output register; a query goes through the prime step, a scan that reads
// one table slot per cycle through the single memory read port, and the result step.
// Reset clears the valid bits of all slots at once; no clearing pass.
// A result waiting in the output register does not block acceptance of the
// next transaction; the sequencer holds at its result step until it is taken.
// ----------------------------------------------------------------------------
module next_alarm_event_select import naes_pkg::*; #(
  parameter int EVENT_SLOTS = EVENT_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [IDX_W-1:0]  event_index_i,
  input  logic [HOUR_W-1:0] hours_i,
  input  logic [MIN_W-1:0]  minutes_i,
  input  logic [DUR_W-1:0]  duration_min_i,
  input  logic [SPD_W-1:0]  speed_percent_i,
  input  logic [SECS_W-1:0] current_seconds_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [IDX_W-1:0]  found_index_o,
  output logic [SECS_W-1:0] alarm_seconds_o,
  output logic [DUR_W-1:0]  found_duration_o,
  output logic [SPD_W-1:0]  found_speed_o,
  output logic [PWM_W-1:0]  pwm_compare_o
);

  naes_ctrl_t  ctrl;
  naes_flags_t flags;

  naes_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  naes_dpath #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .flags_o           (flags),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .event_index_i     (event_index_i),
    .hours_i           (hours_i),
    .minutes_i         (minutes_i),
    .duration_min_i    (duration_min_i),
    .speed_percent_i   (speed_percent_i),
    .current_seconds_i (current_seconds_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .found_index_o     (found_index_o),
    .alarm_seconds_o   (alarm_seconds_o),
    .found_duration_o  (found_duration_o),
    .found_speed_o     (found_speed_o),
    .pwm_compare_o     (pwm_compare_o)
  );

endmodule

/* design/naes_seq.sv */
// ----------------------------------------------------------------------------
// naes_seq
// Step counter with conditional jumps; fetches one control word per step.
// ----------------------------------------------------------------------------
module naes_seq import naes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  naes_flags_t flags_i,
  output naes_ctrl_t  ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  naes_ctrl_t      word;
  logic            take;

  always_comb begin
    word = ucode_fetch(pc_q);
    unique case (word.cond)
      COND_NONE:     take = 1'b0;
      COND_NO_IN:    take = !flags_i.in_valid;
      COND_IS_WRITE: take = flags_i.is_write;
      COND_MORE:     take = flags_i.more;
      COND_OUT_BUSY: take = flags_i.out_busy;
      default:       take = 1'b0;
    endcase
    if (take) begin
      pc_d = word.target;
    end else if (word.done) begin
      pc_d = STEP_ACCEPT;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;

endmodule

/* design/naes_dpath.sv */
// ----------------------------------------------------------------------------
// naes_dpath
// Event table, valid bits, scan counter, best-match registers and output
// register, all driven by the control word of the sequencer.
// ----------------------------------------------------------------------------
module naes_dpath import naes_pkg::*; #(
  parameter int EVENT_SLOTS = EVENT_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  naes_ctrl_t        ctrl_i,
  output naes_flags_t       flags_o,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [IDX_W-1:0]  event_index_i,
  input  logic [HOUR_W-1:0] hours_i,
  input  logic [MIN_W-1:0]  minutes_i,
  input  logic [DUR_W-1:0]  duration_min_i,
  input  logic [SPD_W-1:0]  speed_percent_i,
  input  logic [SECS_W-1:0] current_seconds_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic [IDX_W-1:0]  found_index_o,
  output logic [SECS_W-1:0] alarm_seconds_o,
  output logic [DUR_W-1:0]  found_duration_o,
  output logic [SPD_W-1:0]  found_speed_o,
  output logic [PWM_W-1:0]  pwm_compare_o
);

  localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CNT_W  = $clog2(EVENT_SLOTS + 1);

  // Latched request
  logic              req_q;
  logic [IDX_W-1:0]  idx_q;
  logic [HOUR_W-1:0] hr_q;
  logic [MIN_W-1:0]  mn_q;
  logic [DUR_W-1:0]  dur_q;
  logic [SPD_W-1:0]  spd_q;
  logic [SECS_W-1:0] now_q;

  naes_entry_t       mem_q [EVENT_SLOTS];
  logic              vld_q [EVENT_SLOTS];

  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] rd_addr;
  naes_entry_t       rd_entry_q;
  logic              rd_vld_q;
  logic [SLOT_W-1:0] rd_idx_q;

  logic              have_q;
  logic [SLOT_W-1:0] best_idx_q;
  logic [SECS_W-1:0] best_secs_q;
  logic [DUR_W-1:0]  best_dur_q;
  logic [SPD_W-1:0]  best_spd_q;

  logic              out_valid_q;
  naes_status_e      status_q;
  logic [IDX_W-1:0]  oidx_q;
  logic [SECS_W-1:0] osecs_q;
  logic [DUR_W-1:0]  odur_q;
  logic [SPD_W-1:0]  ospd_q;
  logic [PWM_W-1:0]  opwm_q;

  logic              in_fire;
  logic              out_busy;
  logic              more;
  logic              wr_ok;
  logic              commit_q_res;
  logic              commit_w_res;
  logic [SECS_W-1:0] rd_secs;
  logic              better;
  logic [PROD_W-1:0] pwm_prod;

  assign in_ready_o = ctrl_i.accept;
  assign in_fire    = in_valid_i && ctrl_i.accept;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign more       = cnt_q < CNT_W'(EVENT_SLOTS);
  assign rd_addr    = cnt_q[SLOT_W-1:0];

  assign wr_ok = (hr_q <= MAX_HOUR) && (mn_q <= MAX_MINUTE) && (spd_q <= MAX_SPEED)
              && ({28'd0, idx_q} < 32'(EVENT_SLOTS));

  assign commit_q_res = ctrl_i.load_query && !out_busy;
  assign commit_w_res = ctrl_i.load_write && !out_busy;

  assign rd_secs = SECS_W'(rd_entry_q.hours) * SECS_PER_HOUR
                 + SECS_W'(rd_entry_q.minutes) * SECS_PER_MINUTE;
  assign better  = rd_vld_q && (rd_secs > now_q) && (!have_q || rd_secs < best_secs_q);

  assign pwm_prod = PROD_W'(best_spd_q) * PROD_W'(PWM_RECIP);

  assign flags_o = '{in_valid: in_valid_i, is_write: !req_q, more: more,
                     out_busy: out_busy};

  // Request capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_type_i;
      idx_q <= event_index_i;
      hr_q  <= hours_i;
      mn_q  <= minutes_i;
      dur_q <= duration_min_i;
      spd_q <= speed_percent_i;
      now_q <= current_seconds_i;
    end
  end

  // Table storage and scan read port
  always_ff @(posedge clk_i) begin
    if (commit_w_res && wr_ok) begin
      mem_q[SLOT_W'(idx_q)] <= '{hours: hr_q, minutes: mn_q, duration: dur_q,
                                 speed: spd_q};
    end
    if (ctrl_i.issue_read && more) begin
      rd_entry_q <= mem_q[rd_addr];
      rd_idx_q   <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EVENT_SLOTS; i++) begin
        vld_q[i] <= 1'b0;
      end
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      if (commit_w_res && wr_ok) begin
        vld_q[SLOT_W'(idx_q)] <= 1'b1;
      end
      if (in_fire) begin
        cnt_q  <= '0;
        have_q <= 1'b0;
      end else begin
        if (ctrl_i.issue_read && more) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (ctrl_i.compare && better) begin
          have_q <= 1'b1;
        end
      end
      // a slot past the end reads as empty
      if (ctrl_i.issue_read) begin
        rd_vld_q <= more && vld_q[rd_addr];
      end
    end
  end

  // Best match so far
  always_ff @(posedge clk_i) begin
    if (ctrl_i.compare && better) begin
      best_idx_q  <= rd_idx_q;
      best_secs_q <= rd_secs;
      best_dur_q  <= rd_entry_q.duration;
      best_spd_q  <= rd_entry_q.speed;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_q_res || commit_w_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_w_res) begin
      status_q <= wr_ok ? ST_WR_OK : ST_WR_REJ;
      oidx_q   <= '0;
      osecs_q  <= '0;
      odur_q   <= '0;
      ospd_q   <= '0;
      opwm_q   <= '0;
    end else if (commit_q_res) begin
      if (have_q) begin
        status_q <= ST_FOUND;
        oidx_q   <= IDX_W'(best_idx_q);
        osecs_q  <= best_secs_q;
        odur_q   <= best_dur_q;
        ospd_q   <= best_spd_q;
        opwm_q   <= pwm_prod[PWM_SHIFT +: PWM_W];
      end else begin
        status_q <= ST_NONE;
        oidx_q   <= '0;
        osecs_q  <= '0;
        odur_q   <= '0;
        ospd_q   <= '0;
        opwm_q   <= '0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_index_o    = oidx_q;
  assign alarm_seconds_o  = osecs_q;
  assign found_duration_o = odur_q;
  assign found_speed_o    = ospd_q;
  assign pwm_compare_o    = opwm_q;

endmodule

/* dv/next_alarm_event_select_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_alarm_event_select_test
// Self-checking bench for the event table and next-event query. A model of
// the slot table predicts each result. Random bursts, gaps and output stalls
// drive both channels.
// ----------------------------------------------------------------------------
module next_alarm_event_select_test;
  import naes_pkg::*;

  localparam int SLOTS        = EVENT_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 20;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct {
    naes_status_e      status;
    logic [IDX_W-1:0]  index;
    logic [SECS_W-1:0] secs;
    logic [DUR_W-1:0]  duration;
    logic [SPD_W-1:0]  speed;
    logic [PWM_W-1:0]  pwm;
  } alarm_result_t;

  class next_alarm_scoreboard;
    naes_entry_t   slot_entry[SLOTS];
    bit            slot_armed[SLOTS];
    alarm_result_t due_results[$];
    int            errors;

    function new();
      errors = 0;
      foreach (slot_armed[i]) slot_armed[i] = 1'b0;
    endfunction

    function int unsigned slot_secs(int i);
      return int'(slot_entry[i].hours) * 3600 + int'(slot_entry[i].minutes) * 60;
    endfunction

    // Apply one accepted transaction to the table and queue its result
    function void note_request(logic req, logic [IDX_W-1:0] idx, logic [HOUR_W-1:0] hr,
                               logic [MIN_W-1:0] mn, logic [DUR_W-1:0] dur,
                               logic [SPD_W-1:0] spd, logic [SECS_W-1:0] now);
      alarm_result_t r;
      int unsigned   t;
      int unsigned   best_secs;
      int            best_slot;
      r.status   = ST_WR_OK;
      r.index    = '0;
      r.secs     = '0;
      r.duration = '0;
      r.speed    = '0;
      r.pwm      = '0;
      if (req == REQ_WRITE) begin
        if (hr > MAX_HOUR || mn > MAX_MINUTE || spd > MAX_SPEED || int'(idx) >= SLOTS) begin
          r.status = ST_WR_REJ;
        end else begin
          slot_entry[idx] = '{hours: hr, minutes: mn, duration: dur, speed: spd};
          slot_armed[idx] = 1'b1;
        end
      end else begin
        best_slot = -1;
        best_secs = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_armed[i]) begin
            t = slot_secs(i);
            // strictly later only; lowest slot keeps a tie
            if (t > now && (best_slot < 0 || t < best_secs)) begin
              best_slot = i;
              best_secs = t;
            end
          end
        end
        if (best_slot < 0) begin
          r.status = ST_NONE;
        end else begin
          r.status   = ST_FOUND;
          r.index    = IDX_W'(best_slot);
          r.secs     = SECS_W'(best_secs);
          r.duration = slot_entry[best_slot].duration;
          r.speed    = slot_entry[best_slot].speed;
          r.pwm      = PWM_W'((int'(slot_entry[best_slot].speed) * 1023) / 100);
        end
      end
      due_results.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(alarm_result_t got);
      alarm_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 got.status);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("found_index", want.index, got.index);
      compare_field("alarm_seconds", want.secs, got.secs);
      compare_field("found_duration", want.duration, got.duration);
      compare_field("found_speed", want.speed, got.speed);
      compare_field("pwm_compare", want.pwm, got.pwm);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              req_type_i;
  logic [IDX_W-1:0]  event_index_i;
  logic [HOUR_W-1:0] hours_i;
  logic [MIN_W-1:0]  minutes_i;
  logic [DUR_W-1:0]  duration_min_i;
  logic [SPD_W-1:0]  speed_percent_i;
  logic [SECS_W-1:0] current_seconds_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [STAT_W-1:0] status_o;
  logic [IDX_W-1:0]  found_index_o;
  logic [SECS_W-1:0] alarm_seconds_o;
  logic [DUR_W-1:0]  found_duration_o;
  logic [SPD_W-1:0]  found_speed_o;
  logic [PWM_W-1:0]  pwm_compare_o;

  next_alarm_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  next_alarm_event_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .event_index_i    (event_index_i),
    .hours_i          (hours_i),
    .minutes_i        (minutes_i),
    .duration_min_i   (duration_min_i),
    .speed_percent_i  (speed_percent_i),
    .current_seconds_i(current_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .found_index_o    (found_index_o),
    .alarm_seconds_o  (alarm_seconds_o),
    .found_duration_o (found_duration_o),
    .found_speed_o    (found_speed_o),
    .pwm_compare_o    (pwm_compare_o)
  );

  always #2 clk_i = ~clk_i;

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin : watch
    alarm_result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.status   = naes_status_e'(status_o);
        got.index    = found_index_o;
        got.secs     = alarm_seconds_o;
        got.duration = found_duration_o;
        got.speed    = found_speed_o;
        got.pwm      = pwm_compare_o;
        sb.check_result(got);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_request(req_type_i, event_index_i, hours_i, minutes_i, duration_min_i,
                        speed_percent_i, current_seconds_i);
      end
    end
  end

  // Receiver: pick a new stall pattern whenever the current one runs out
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready_i <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready_i <= ((stall_tick % 7) < 3);
      end
    endcase
  end

  task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                           input logic [HOUR_W-1:0] hr, input logic [MIN_W-1:0] mn,
                           input logic [DUR_W-1:0] dur, input logic [SPD_W-1:0] spd,
                           input logic [SECS_W-1:0] now);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    req_type_i        <= req;
    event_index_i     <= idx;
    hours_i           <= hr;
    minutes_i         <= mn;
    duration_min_i    <= dur;
    speed_percent_i   <= spd;
    current_seconds_i <= now;
    // hold until the transaction is taken
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_item();
    int unsigned       pick;
    int unsigned       slot;
    int unsigned       t;
    logic [IDX_W-1:0]  idx;
    logic [HOUR_W-1:0] hr;
    logic [MIN_W-1:0]  mn;
    logic [DUR_W-1:0]  dur;
    logic [SPD_W-1:0]  spd;
    logic [SECS_W-1:0] now;
    pick = $urandom_range(0, 99);
    idx  = IDX_W'($urandom);
    hr   = HOUR_W'($urandom);
    mn   = MIN_W'($urandom);
    dur  = DUR_W'($urandom);
    spd  = SPD_W'($urandom);
    now  = SECS_W'($urandom);
    if (pick < 40) begin
      hr  = HOUR_W'($urandom_range(0, 23));
      mn  = MIN_W'($urandom_range(0, 59));
      spd = SPD_W'($urandom_range(0, 100));
      // crowd a few hours onto quarter marks so ties turn up
      if ($urandom_range(0, 3) == 0) begin
        hr = HOUR_W'($urandom_range(6, 8));
        mn = MIN_W'(15 * $urandom_range(0, 3));
      end
      if ($urandom_range(0, 9) == 0) spd = $urandom_range(0, 1) ? MAX_SPEED : '0;
      send_item(REQ_WRITE, idx, hr, mn, dur, spd, now);
    end else if (pick < 50) begin
      case ($urandom_range(0, 2))
        0: begin
          hr = HOUR_W'($urandom_range(24, 31));
        end
        1: begin
          mn = MIN_W'($urandom_range(60, 63));
        end
        default: begin
          spd = SPD_W'($urandom_range(101, 127));
        end
      endcase
      send_item(REQ_WRITE, idx, hr, mn, dur, spd, now);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        now = SECS_W'($urandom_range(0, 86399));
      end else if (pick < 8) begin
        // land just before, on or just after a stored alarm
        slot = $urandom_range(0, SLOTS - 1);
        t    = sb.slot_armed[slot] ? sb.slot_secs(slot) : $urandom_range(0, 86399);
        now  = (t == 0) ? '0 : SECS_W'(t + $urandom_range(0, 2) - 1);
      end else if (pick == 8) begin
        now = SECS_W'($urandom_range(86340, 131071));
      end else begin
        now = SECS_W'($urandom_range(0, 5));
      end
      send_item(REQ_QUERY, idx, hr, mn, dur, spd, now);
    end
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    req_type_i        = REQ_WRITE;
    event_index_i     = '0;
    hours_i           = '0;
    minutes_i         = '0;
    duration_min_i    = '0;
    speed_percent_i   = '0;
    current_seconds_i = '0;
    out_ready_i       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, range limits, extremes
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd0);
    send_item(REQ_WRITE, 4'd15, 5'd23, 6'd59, 8'd255, 7'd100, 17'd0);
    send_item(REQ_WRITE, 4'd1, 5'd24, 6'd0, 8'd1, 7'd10, 17'd0);
    send_item(REQ_WRITE, 4'd2, 5'd31, 6'd63, 8'd1, 7'd127, 17'd0);
    send_item(REQ_WRITE, 4'd2, 5'd5, 6'd60, 8'd1, 7'd10, 17'd0);
    send_item(REQ_WRITE, 4'd2, 5'd5, 6'd5, 8'd1, 7'd101, 17'd0);
    send_item(REQ_WRITE, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd0);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd0);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd86339);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd86340);
    send_item(REQ_QUERY, 4'd15, 5'd31, 6'd63, 8'd255, 7'd127, 17'd131071);
    // tie on equal times, then overwrite the winner
    send_item(REQ_WRITE, 4'd3, 5'd6, 6'd30, 8'd10, 7'd50, 17'd0);
    send_item(REQ_WRITE, 4'd7, 5'd6, 6'd30, 8'd20, 7'd75, 17'd0);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd23399);
    send_item(REQ_WRITE, 4'd3, 5'd7, 6'd0, 8'd30, 7'd1, 17'd0);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd23399);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd23400);
    send_item(REQ_QUERY, 4'd0, 5'd0, 6'd0, 8'd0, 7'd0, 17'd86399);

    repeat (RANDOM_ITEMS) random_item();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("next_alarm_event_select verification clean");
    end else begin
      $display("next_alarm_event_select verification failed");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, %0d results outstanding", $time, sb.due_results.size());
    $display("next_alarm_event_select verification failed");
    $finish;
  end

endmodule

/* next_alarm_event_select.f */
design/naes_pkg.sv
design/naes_seq.sv
design/naes_dpath.sv
design/next_alarm_event_select.sv
dv/next_alarm_event_select_test.sv
